// ----- sv/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/gbsd_pkg.sv -----
// shared types, constants and helper function of the golomb bit-serial decoder
`default_nettype none

package gbsd_pkg;

    localparam int DIV_W          = 32;
    localparam int RS_W           = 33;
    localparam int BR_W           = 6;
    localparam int UB_W           = 6;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(2);

    typedef enum logic [1:0] {
        PH_UNARY = 2'd0,
        PH_REM   = 2'd1,
        PH_EXTRA = 2'd2
    } phase_t;

    // divisor and the code lengths derived from it
    typedef struct packed {
        logic [DIV_W-1:0] b;
        logic [UB_W-1:0]  ub;
        logic [UB_W-1:0]  lb;
        logic [RS_W-1:0]  nr;
    } cfg_t;

    function automatic cfg_t derive_cfg(input logic [DIV_W-1:0] div);
        cfg_t             c;
        logic [DIV_W-1:0] dm1;
        logic [UB_W-1:0]  k;
        c.b = (div < DIV_W'(2)) ? DIV_W'(1) : div;
        dm1 = c.b - DIV_W'(1);
        // ceil(log2 b) is the bit length of b-1
        k   = '0;
        for (int i = 0; i < DIV_W; i++) begin
            if (dm1[i]) begin
                k = UB_W'(i + 1);
            end
        end
        c.ub = k;
        c.lb = (k == '0) ? '0 : k - UB_W'(1);
        c.nr = (RS_W'(1) << k) - RS_W'(c.b);
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gbsd_cfg_regs.sv -----
// divisor register with its derived code lengths
`default_nettype none

module gbsd_cfg_regs
    import gbsd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [DIV_W-1:0] wr_divisor,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // derived lengths are settled at write time, off the decode path
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            cfg_next = derive_cfg(wr_divisor);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= derive_cfg(DIVISOR_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/gbsd_step.sv -----
// one decode step: next code state and the finished value for one code bit
`default_nettype none

module gbsd_step
    import gbsd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire cfg_t              cfg,
    input  wire logic              code_bit,
    input  wire phase_t            phase,
    input  wire logic [VALUE_BITS-1:0] base_sum,
    input  wire logic [RS_W-1:0]   rem_shift,
    input  wire logic [BR_W-1:0]   bits_read,
    input  wire logic              ovf_seen,
    output phase_t                 phase_next,
    output logic [VALUE_BITS-1:0]  base_sum_next,
    output logic [RS_W-1:0]        rem_shift_next,
    output logic [BR_W-1:0]        bits_read_next,
    output logic                   ovf_seen_next,
    output logic                   emit,
    output logic [VALUE_BITS-1:0]  emit_value,
    output logic                   emit_overflow
);

    localparam int SUM_W = ((VALUE_BITS > DIV_W) ? VALUE_BITS : DIV_W) + 1;
    localparam int TOT_W = ((VALUE_BITS > RS_W) ? VALUE_BITS : RS_W) + 1;
    localparam logic [SUM_W-1:0] MAXV_S = {{(SUM_W-VALUE_BITS){1'b0}}, {VALUE_BITS{1'b1}}};
    localparam logic [TOT_W-1:0] MAXV_T = {{(TOT_W-VALUE_BITS){1'b0}}, {VALUE_BITS{1'b1}}};

    logic [RS_W-1:0]  shifted;
    logic [RS_W-1:0]  extra_rs;
    logic [BR_W-1:0]  br_inc;
    logic [SUM_W-1:0] unary_sum;
    logic             rem_done;
    logic             rem_long;
    logic             nr_zero;
    logic             b_one;
    logic [RS_W-1:0]  rs_emit;
    logic [TOT_W-1:0] total;

    assign shifted   = {rem_shift[RS_W-2:0], code_bit};
    assign extra_rs  = shifted - cfg.nr;
    assign br_inc    = bits_read + BR_W'(1);
    assign unary_sum = SUM_W'(base_sum) + SUM_W'(cfg.b);
    assign rem_done  = (br_inc >= BR_W'(cfg.lb));
    assign rem_long  = (shifted >= cfg.nr);
    assign nr_zero   = (cfg.nr == '0);
    assign b_one     = (cfg.ub == '0);

    // phase sequencing
    always_comb begin
        unique case (phase)
            PH_REM: begin
                if (rem_done && rem_long) begin
                    phase_next = PH_EXTRA;
                end else if (rem_done) begin
                    phase_next = PH_UNARY;
                end else begin
                    phase_next = PH_REM;
                end
            end
            PH_EXTRA: begin
                phase_next = PH_UNARY;
            end
            default: begin
                if (code_bit || b_one) begin
                    phase_next = PH_UNARY;
                end else if (cfg.lb == '0) begin
                    phase_next = nr_zero ? PH_EXTRA : PH_UNARY;
                end else begin
                    phase_next = PH_REM;
                end
            end
        endcase
    end

    // datapath and result
    always_comb begin
        base_sum_next  = base_sum;
        rem_shift_next = rem_shift;
        bits_read_next = bits_read;
        ovf_seen_next  = ovf_seen;
        emit           = 1'b0;
        rs_emit        = '0;
        unique case (phase)
            PH_REM: begin
                rem_shift_next = shifted;
                bits_read_next = br_inc;
                emit           = rem_done && !rem_long;
                rs_emit        = shifted;
            end
            PH_EXTRA: begin
                emit    = 1'b1;
                rs_emit = extra_rs;
            end
            default: begin
                if (code_bit) begin
                    if (unary_sum > MAXV_S) begin
                        base_sum_next = {VALUE_BITS{1'b1}};
                        ovf_seen_next = 1'b1;
                    end else begin
                        base_sum_next = unary_sum[VALUE_BITS-1:0];
                    end
                end else begin
                    rem_shift_next = '0;
                    bits_read_next = '0;
                    emit           = b_one || (cfg.lb == '0 && !nr_zero);
                end
            end
        endcase
        // a finished code leaves the state clear for the next one
        if (emit) begin
            base_sum_next  = '0;
            rem_shift_next = '0;
            bits_read_next = '0;
            ovf_seen_next  = 1'b0;
        end
    end

    assign total = TOT_W'(base_sum) + TOT_W'(rs_emit);

    always_comb begin
        if (total > MAXV_T) begin
            emit_value    = {VALUE_BITS{1'b1}};
            emit_overflow = 1'b1;
        end else begin
            emit_value    = total[VALUE_BITS-1:0];
            emit_overflow = ovf_seen;
        end
    end

endmodule

`default_nettype wire

// ----- sv/golomb_bit_serial_decoder_top.sv -----
// golomb bit-serial decoder top level: input stage, code state and result register
//
// Usage:
//   s_valid/s_ready/s_code_bit carry one bit of the coded stream per beat, in
//   stream order. m_valid/m_ready/m_decoded_value/m_overflow carry one beat per
//   finished code: quotient*b + remainder, saturated at all ones with
//   m_overflow set when the true value does not fit.
//   cfg_valid/cfg_ready/cfg_divisor write the divisor b (reset 2); values 0
//   and 1 give a pure unary code. Write it only while no code bit is in flight.
//   A bit accepted goes into the input stage; its decode step then updates the
//   code state and loads any result it completes into the result register.
//   Throughput: one code bit per cycle while m_ready does not stall a result; the
//   decode step is a single registered pass of adds, a subtract and compares,
//   with the input stage and the result register as its two ends.
//   A stalled m_ready holds the result; one more bit may wait in the input stage,
//   then s_ready drops until the result beat is taken.
//   Reset (aresetn low, synchronous) empties both stages, puts the decoder at the
//   start of a code and sets the divisor to 2; no beat is taken while it is held.
`default_nettype none

module golomb_bit_serial_decoder_top
    import gbsd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_code_bit,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VALUE_BITS-1:0]      m_decoded_value,
    output logic                       m_overflow,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [DIV_W-1:0]      cfg_divisor
);

    cfg_t cfg;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  in_bit_reg;
    logic                  in_bit_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [VALUE_BITS-1:0] base_sum_reg;
    logic [VALUE_BITS-1:0] base_sum_next;
    logic [RS_W-1:0]       rem_shift_reg;
    logic [RS_W-1:0]       rem_shift_next;
    logic [BR_W-1:0]       bits_read_reg;
    logic [BR_W-1:0]       bits_read_next;
    logic                  ovf_seen_reg;
    logic                  ovf_seen_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [VALUE_BITS-1:0] m_value_next;
    logic                  m_ovf_reg;
    logic                  m_ovf_next;

    logic                  emit;
    logic [VALUE_BITS-1:0] emit_value;
    logic                  emit_overflow;
    logic                  advance;
    logic                  s_beat;

    assign cfg_ready = aresetn;

    gbsd_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_divisor (cfg_divisor),
        .cfg        (cfg)
    );

    gbsd_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .cfg            (cfg),
        .code_bit       (in_bit_reg),
        .phase          (phase_reg),
        .base_sum       (base_sum_reg),
        .rem_shift      (rem_shift_reg),
        .bits_read      (bits_read_reg),
        .ovf_seen       (ovf_seen_reg),
        .phase_next     (phase_next),
        .base_sum_next  (base_sum_next),
        .rem_shift_next (rem_shift_next),
        .bits_read_next (bits_read_next),
        .ovf_seen_next  (ovf_seen_next),
        .emit           (emit),
        .emit_value     (emit_value),
        .emit_overflow  (emit_overflow)
    );

    // a bit is decoded once the result slot is free or being drained
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_bit_next   = in_bit_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
            in_bit_next   = s_code_bit;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_value_next = m_value_reg;
        m_ovf_next   = m_ovf_reg;
        if (advance) begin
            m_valid_next = emit;
            if (emit) begin
                m_value_next = emit_value;
                m_ovf_next   = emit_overflow;
            end
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            phase_reg     <= PH_UNARY;
            base_sum_reg  <= '0;
            rem_shift_reg <= '0;
            bits_read_reg <= '0;
            ovf_seen_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                phase_reg     <= phase_next;
                base_sum_reg  <= base_sum_next;
                rem_shift_reg <= rem_shift_next;
                bits_read_reg <= bits_read_next;
                ovf_seen_reg  <= ovf_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_bit_reg  <= in_bit_next;
        m_value_reg <= m_value_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_decoded_value = m_value_reg;
    assign m_overflow      = m_ovf_reg;

endmodule

`default_nettype wire

// ----- sv/gbsd_checker.sv -----
// port-level checker for the golomb bit-serial decoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module gbsd_checker
    import gbsd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_code_bit,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [VALUE_BITS-1:0] m_decoded_value,
    input wire logic                  m_overflow,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [DIV_W-1:0]      cfg_divisor
);

    // a stalled result beat must hold
    `ASSERT_CLK(a_m_hold, m_valid && !m_ready |=> m_valid && $stable(m_decoded_value) && $stable(m_overflow), "result beat changed while stalled")

    // an overflowed value is always saturated
    `ASSERT_CLK(a_ovf_sat, m_valid && m_overflow |-> &m_decoded_value, "overflow without saturation")

    // a new result needs a code bit taken into the input stage and then decoded into the result register
    `ASSERT_CLK(a_rise_src, $rose(m_valid) |-> $past(s_valid && s_ready && s_code_bit == s_code_bit, 2), "result with no input beat behind it")

    // nothing is offered right after a reset edge
    `ASSERT_CLK_NR(a_rst_empty, !aresetn |=> !m_valid, "result valid after reset")

    // no configuration beat is taken during reset
    `ASSERT_CLK_NR(a_rst_cfg, !aresetn |-> !(cfg_valid && cfg_ready) && cfg_divisor == cfg_divisor, "config beat taken in reset")

endmodule

bind golomb_bit_serial_decoder_top gbsd_checker #(.VALUE_BITS(VALUE_BITS)) u_gbsd_checker (.*);

`default_nettype wire

// ----- tb/sv/golomb_bit_serial_decoder_top_tb.sv -----
// self-checking testbench for the golomb bit-serial decoder top level
`default_nettype none

module golomb_bit_serial_decoder_top_tb;
    import gbsd_pkg::*;

    localparam int          VALUE_BITS = VALUE_BITS_DEF;
    localparam logic [63:0] MAX_VALUE  = (64'd1 << VALUE_BITS) - 64'd1;
    localparam int unsigned ITEMS      = 1400;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam int unsigned MAX_WAIT   = 18;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  ovf;
    } golomb_result_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_code_bit  = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [VALUE_BITS-1:0] m_decoded_value;
    logic                  m_overflow;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [DIV_W-1:0]      cfg_divisor = '0;

    golomb_bit_serial_decoder_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_bit     (s_code_bit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decoded_value(m_decoded_value),
        .m_overflow     (m_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_divisor    (cfg_divisor)
    );

    // bits waiting for the driver and decoded values waiting for the dut
    logic           code_bits_q[$];
    golomb_result_t expected_values[$];

    int unsigned bits_pushed     = 0;
    int unsigned bits_taken      = 0;
    int unsigned results_checked = 0;
    int unsigned saturated_seen  = 0;
    int unsigned divisor_writes  = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    bit          s_took          = 1'b0;
    bit          m_took          = 1'b0;
    bit          s_calm          = 1'b0;
    bit          m_calm          = 1'b1;

    // predictor copy of the divisor and the code in progress
    logic [DIV_W-1:0] dec_divisor = DIVISOR_RESET;
    phase_t           dec_phase   = PH_UNARY;
    logic [63:0]      dec_base    = '0;
    logic [RS_W-1:0]  dec_rem     = '0;
    logic [BR_W-1:0]  dec_nbits   = '0;
    logic             dec_ovf     = 1'b0;

    // divisor the stimulus encodes with
    logic [DIV_W-1:0] gen_div = DIVISOR_RESET;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] eff_divisor(input logic [DIV_W-1:0] d);
        return (d < DIV_W'(2)) ? 64'd1 : 64'(d);
    endfunction

    function automatic int unsigned code_len(input logic [63:0] b);
        int unsigned k;
        k = 0;
        while (k < 40 && (64'd1 << k) < b) begin
            k++;
        end
        return k;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // one code bit into the decoder; returns 1 when a value comes out
    function automatic bit decode_step(input logic cbit, output golomb_result_t res);
        logic [63:0] b;
        logic [63:0] nr;
        logic [63:0] total;
        int unsigned ub;
        int unsigned lb;
        bit          plain_done;
        bit          emit_now;
        b          = eff_divisor(dec_divisor);
        ub         = code_len(b);
        lb         = (ub == 0) ? 0 : ub - 1;
        nr         = (64'd1 << ub) - b;
        plain_done = 1'b0;
        emit_now   = 1'b0;
        res        = '0;
        case (dec_phase)
            PH_REM: begin
                dec_rem    = {dec_rem[RS_W-2:0], cbit};
                dec_nbits  = dec_nbits + BR_W'(1);
                plain_done = (dec_nbits >= lb);
            end
            PH_EXTRA: begin
                dec_rem  = RS_W'({dec_rem[RS_W-2:0], cbit} - nr);
                emit_now = 1'b1;
            end
            default: begin
                dec_phase = PH_UNARY;
                if (cbit) begin
                    dec_base = dec_base + b;
                    if (dec_base > MAX_VALUE) begin
                        dec_base = MAX_VALUE;
                        dec_ovf  = 1'b1;
                    end
                end else begin
                    dec_rem   = '0;
                    dec_nbits = '0;
                    if (b < 64'd2) begin
                        emit_now = 1'b1;
                    end else if (lb == 0) begin
                        plain_done = 1'b1;
                    end else begin
                        dec_phase = PH_REM;
                    end
                end
            end
        endcase
        // short remainders end here, long ones take one more bit
        if (plain_done) begin
            if (64'(dec_rem) >= nr) begin
                dec_phase = PH_EXTRA;
            end else begin
                emit_now = 1'b1;
            end
        end
        if (emit_now) begin
            total = dec_base + 64'(dec_rem);
            res.ovf = dec_ovf;
            if (total > MAX_VALUE) begin
                total   = MAX_VALUE;
                res.ovf = 1'b1;
            end
            res.value = total[VALUE_BITS-1:0];
            dec_phase = PH_UNARY;
            dec_base  = '0;
            dec_rem   = '0;
            dec_nbits = '0;
            dec_ovf   = 1'b0;
        end
        return emit_now;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic push_bit(input logic v);
        code_bits_q.push_back(v);
        bits_pushed++;
    endtask

    // golomb code of q*b + r under the current divisor
    task automatic push_code(input int unsigned q, input logic [63:0] r);
        logic [63:0] b;
        logic [63:0] nr;
        logic [63:0] word;
        int unsigned ub;
        int          nb;
        b  = eff_divisor(gen_div);
        ub = code_len(b);
        nr = (64'd1 << ub) - b;
        repeat (q) push_bit(1'b1);
        push_bit(1'b0);
        if (b < 64'd2) begin
            return;
        end
        if (r < nr) begin
            word = r;
            nb   = int'(ub) - 1;
        end else begin
            word = r + nr;
            nb   = int'(ub);
        end
        for (int i = nb - 1; i >= 0; i--) begin
            push_bit(word[i]);
        end
    endtask

    task automatic write_divisor(input logic [DIV_W-1:0] d);
        @(negedge aclk);
        cfg_divisor <= d;
        cfg_valid   <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_div = d;
    endtask

    // all bits taken, all values out, then a further wait for a bit still in the pipe
    task automatic wait_drained();
        do @(negedge aclk); while (bits_taken != bits_pushed || expected_values.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    always @(negedge aclk) begin : bit_driver
        int unsigned gap_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_code_bit <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || s_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (code_bits_q.size() != 0) begin
                s_code_bit <= code_bits_q.pop_front();
                s_valid    <= 1'b1;
                gap_left = draw_wait(s_calm);
                if ($urandom_range(0, 39) == 0) begin
                    s_calm = !s_calm;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        int unsigned stall_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_took) begin
                stall_left = draw_wait(m_calm);
                if ($urandom_range(0, 29) == 0) begin
                    m_calm = !m_calm;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        golomb_result_t got;
        golomb_result_t want;
        s_took = 1'b0;
        m_took = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                dec_divisor = cfg_divisor;
                divisor_writes++;
            end
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                bits_taken++;
                if (decode_step(s_code_bit, got)) begin
                    expected_values.push_back(got);
                end
            end
            if (m_valid && m_ready) begin
                m_took = 1'b1;
                results_checked++;
                if (m_overflow === 1'b1) begin
                    saturated_seen++;
                end
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected value %0d overflow %0b",
                                              m_decoded_value, m_overflow));
                end else begin
                    want = expected_values.pop_front();
                    if (m_decoded_value !== want.value) begin
                        report_mismatch($sformatf("decoded_value %0d, expected %0d",
                                                  m_decoded_value, want.value));
                    end
                    if (m_overflow !== want.ovf) begin
                        report_mismatch($sformatf("overflow %0b, expected %0b (value %0d)",
                                                  m_overflow, want.ovf, want.value));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      phase_no;
        int unsigned      n_codes;
        int unsigned      q;
        logic [63:0]      r;
        logic [63:0]      b;
        logic [DIV_W-1:0] d;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset divisor of two: one remainder bit after the terminator
        push_code(0, 0);
        push_code(0, 1);
        push_code(2, 0);
        wait_drained();
        // divisor below two: pure unary, value out on the terminator
        write_divisor(32'd0);
        push_code(0, 0);
        push_code(3, 0);
        wait_drained();
        // divisor five: short and long remainders
        write_divisor(32'd5);
        push_code(0, 0);
        push_code(1, 4);
        push_code(0, 2);
        // leave a code open so the next setting lands mid-code
        push_bit(1'b1);
        push_bit(1'b0);
        wait_drained();

        phase_no = 0;
        while (bits_pushed < ITEMS) begin
            case (phase_no)
                0: d = 32'hFFFF_FFFF;
                1: d = 32'h8000_0001;
                2: d = 32'h8000_0000;
                3: d = 32'd1;
                4: d = 32'd3;
                5: d = 32'hFFFF_FFFE;
                default: begin
                    case ($urandom_range(0, 5))
                        0: d = $urandom_range(2, 16);
                        1: d = 32'd1 << $urandom_range(1, 31);
                        2: d = $urandom_range(17, 5000);
                        3: d = $urandom;
                        4: d = $urandom_range(0, 1);
                        default: d = $urandom_range(2, 4);
                    endcase
                end
            endcase
            write_divisor(d);
            b = eff_divisor(d);
            n_codes = $urandom_range(4, 20);
            for (int i = 0; i < n_codes; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    repeat ($urandom_range(1, 6)) push_bit(1'($urandom_range(0, 1)));
                end else begin
                    // big divisors saturate after a couple of unary ones
                    if (b > 64'h4000_0000) begin
                        q = $urandom_range(0, 3);
                    end else if ($urandom_range(0, 9) == 0) begin
                        q = $urandom_range(7, 24);
                    end else begin
                        q = $urandom_range(0, 6);
                    end
                    case ($urandom_range(0, 5))
                        0: r = 64'd0;
                        1: r = b - 64'd1;
                        default: r = 64'($urandom) % b;
                    endcase
                    push_code(q, r);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, 2)) push_bit(1'b1);
                push_bit(1'b0);
            end
            wait_drained();
            phase_no++;
        end

        repeat (10) @(negedge aclk);
        $display("decoded %0d code bits under %0d divisor writes, %0d values checked",
                 bits_taken, divisor_writes, results_checked);
        $display("%0d values saturated, %0d mismatches", saturated_seen, mismatches);
        if (mismatches == 0 && expected_values.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
